// File: rtl/lsw_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the lidar
// scan-to-world point pipeline. No dependencies.
package lsw_pkg;

    localparam int RANGE_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF = 16;

    // CORDIC datapath: Q30 values with headroom for sign and growth
    localparam int CORDIC_ITERS = 30;
    localparam int CW = 33;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

    // Rotation matrix entries in Q28 with room for a non-unit quaternion
    localparam int MAT_W = 35;
    localparam logic signed [MAT_W-1:0] MAT_ONE = 35'sd268435456;

    // Result coordinates
    localparam int PT_W = 25;
    localparam int BEAM_W = 16;
    localparam int RANGE_W = 16;

    localparam logic [63:0] QUAT_RESET = 64'h0000_0000_4000_0000;

    typedef enum logic [2:0] {
        CFG_ANGLE_START = 3'd0,
        CFG_ANGLE_STEP  = 3'd1,
        CFG_ROT_QUAT    = 3'd2,
        CFG_OFFSET_X    = 3'd3,
        CFG_OFFSET_Y    = 3'd4,
        CFG_OFFSET_Z    = 3'd5
    } t_cfg_reg;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051D;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/lsw_angle.sv
// Beam angle stages: angle = start + index * step, then fold into the right
// half plane and seed the CORDIC. Depends on lsw_pkg.
module lsw_angle #(
    parameter int ANGLE_BITS = lsw_pkg::ANGLE_BITS_DEF,
    parameter int INDEX_BITS = lsw_pkg::INDEX_BITS_DEF,
    parameter int SIDE_W     = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [INDEX_BITS-1:0]         i_index,
    input  logic [SIDE_W-1:0]             i_side,
    input  logic [15:0]                   i_angle_start,
    input  logic [15:0]                   i_angle_step,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [lsw_pkg::CW-1:0] o_x,
    output logic signed [lsw_pkg::CW-1:0] o_y,
    output logic signed [lsw_pkg::CW-1:0] o_z,
    output logic                          o_flip,
    output logic [SIDE_W-1:0]             o_side
);
    import lsw_pkg::*;

    localparam int PW = ANGLE_BITS + INDEX_BITS;

    logic                  r_v1, r_v2;
    logic                  w_rdy1, w_rdy2;
    logic [ANGLE_BITS-1:0] r_ang;
    logic [SIDE_W-1:0]     r_side1, r_side2;
    logic [ANGLE_BITS-1:0] w_start, w_step;
    logic [PW-1:0]         w_prod;
    logic [ANGLE_BITS-1:0] n_ang;
    logic [31:0]           w_a32, w_fold;
    logic                  w_flip;
    logic signed [CW-1:0]  r_z;
    logic                  r_flip;

    // Stage readiness: a stage takes a word when empty or when it moves on
    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Angle sum, wrapping modulo the angle width
    assign w_start = ANGLE_BITS'(i_angle_start);
    assign w_step  = ANGLE_BITS'($signed(i_angle_step));
    assign w_prod  = PW'(i_index) * PW'(w_step);
    assign n_ang   = w_start + w_prod[ANGLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
        if (w_rdy1) begin
            r_ang   <= n_ang;
            r_side1 <= i_side;
        end
    end

    // Fold the left half plane by half a turn; negate the result later
    assign w_a32  = {r_ang, {(32-ANGLE_BITS){1'b0}}};
    assign w_flip = w_a32[31] ^ w_a32[30];
    assign w_fold = w_flip ? {~w_a32[31], w_a32[30:0]} : w_a32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (w_rdy2) begin
            r_z     <= CW'($signed(w_fold));
            r_flip  <= w_flip;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_x     = CORDIC_GAIN;
    assign o_y     = '0;
    assign o_z     = r_z;
    assign o_flip  = r_flip;
    assign o_side  = r_side2;

endmodule

// File: rtl/lsw_cordic_stage.sv
// One CORDIC rotation iteration with its pipeline register.
// Depends on lsw_pkg for the datapath width and arctangent table.
module lsw_cordic_stage #(
    parameter int ITER   = 0,
    parameter int SIDE_W = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [lsw_pkg::CW-1:0] i_x,
    input  logic signed [lsw_pkg::CW-1:0] i_y,
    input  logic signed [lsw_pkg::CW-1:0] i_z,
    input  logic                          i_flip,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [lsw_pkg::CW-1:0] o_x,
    output logic signed [lsw_pkg::CW-1:0] o_y,
    output logic signed [lsw_pkg::CW-1:0] o_z,
    output logic                          o_flip,
    output logic [SIDE_W-1:0]             o_side
);
    import lsw_pkg::*;

    localparam logic signed [CW-1:0] ATAN = CW'(atan_turn(ITER));

    logic                 r_valid;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic signed [CW-1:0] n_x, n_y, n_z;
    logic signed [CW-1:0] w_xs, w_ys;
    logic                 r_flip;
    logic [SIDE_W-1:0]    r_side;

    assign o_ready = !r_valid || i_ready;

    // Rotate towards zero residual angle; shifts round towards minus infinity
    assign w_xs = i_x >>> ITER;
    assign w_ys = i_y >>> ITER;

    always_comb begin
        if (!i_z[CW-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_flip <= i_flip;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flip  = r_flip;
    assign o_side  = r_side;

endmodule

// File: rtl/lsw_project.sv
// Scale cos/sin by range, rotate by the quaternion matrix and add the offset,
// saturating to the output range. Depends on lsw_pkg.
module lsw_project #(
    parameter int RANGE_BITS = lsw_pkg::RANGE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [lsw_pkg::CW-1:0]        i_x,
    input  logic signed [lsw_pkg::CW-1:0]        i_y,
    input  logic                                 i_flip,
    input  logic [lsw_pkg::BEAM_W+RANGE_BITS-1:0] i_side,
    input  logic [63:0]                          i_quat,
    input  logic [23:0]                          i_offset_x,
    input  logic [23:0]                          i_offset_y,
    input  logic [23:0]                          i_offset_z,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [lsw_pkg::PT_W-1:0]      o_px,
    output logic signed [lsw_pkg::PT_W-1:0]      o_py,
    output logic signed [lsw_pkg::PT_W-1:0]      o_pz,
    output logic [lsw_pkg::BEAM_W-1:0]           o_beam
);
    import lsw_pkg::*;

    localparam int NST = 6;
    localparam int PW  = RANGE_BITS + 1 + CW;
    localparam int VW  = RANGE_BITS + 6;
    localparam int MW  = MAT_W + VW;
    localparam int AW  = MW + 1;
    localparam int TW  = AW - 32;
    localparam int FW  = ((TW > PT_W) ? TW : PT_W) + 2;
    localparam logic signed [FW-1:0] PT_MAX = FW'(25'sh0FFFFFF);
    localparam logic signed [FW-1:0] PT_MIN = FW'(-26'sd16777216);

    logic [NST-1:0] r_v;
    logic [NST:0]   w_rdy;

    // Bubble-collapsing readiness along the stages
    always_comb begin
        w_rdy[NST] = i_ready;
        for (int k = 0; k < NST; k++) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Quaternion matrix; user changes configuration only when idle, not enforced
    logic signed [15:0]      w_qw, w_qx, w_qy, w_qz;
    logic signed [31:0]      r_xy, r_wz, r_yy, r_zz, r_xx, r_xz, r_wy, r_yz, r_wx;
    logic signed [MAT_W-1:0] r_m00, r_m01, r_m10, r_m11, r_m20, r_m21;

    assign w_qw = i_quat[63:48];
    assign w_qx = i_quat[47:32];
    assign w_qy = i_quat[31:16];
    assign w_qz = i_quat[15:0];

    always_ff @(posedge i_clk) begin
        r_xy  <= w_qx * w_qy;
        r_wz  <= w_qw * w_qz;
        r_yy  <= w_qy * w_qy;
        r_zz  <= w_qz * w_qz;
        r_xx  <= w_qx * w_qx;
        r_xz  <= w_qx * w_qz;
        r_wy  <= w_qw * w_qy;
        r_yz  <= w_qy * w_qz;
        r_wx  <= w_qw * w_qx;
        r_m00 <= MAT_ONE - ((MAT_W'(r_yy) + MAT_W'(r_zz)) <<< 1);
        r_m01 <= (MAT_W'(r_xy) - MAT_W'(r_wz)) <<< 1;
        r_m10 <= (MAT_W'(r_xy) + MAT_W'(r_wz)) <<< 1;
        r_m11 <= MAT_ONE - ((MAT_W'(r_xx) + MAT_W'(r_zz)) <<< 1);
        r_m20 <= (MAT_W'(r_xz) - MAT_W'(r_wy)) <<< 1;
        r_m21 <= (MAT_W'(r_yz) + MAT_W'(r_wx)) <<< 1;
    end

    // Stage 0: undo the half-turn fold
    logic signed [CW-1:0]   r_c, r_s;
    logic [RANGE_BITS-1:0]  r_rng0;
    logic [BEAM_W-1:0]      r_beam [0:NST-1];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_c       <= i_flip ? -i_x : i_x;
            r_s       <= i_flip ? -i_y : i_y;
            r_rng0    <= i_side[BEAM_W +: RANGE_BITS];
            r_beam[0] <= i_side[BEAM_W-1:0];
        end
    end

    // Stage 1: range times cos and sin
    logic signed [PW-1:0] r_pc, r_ps;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_pc      <= $signed({1'b0, r_rng0}) * r_c;
            r_ps      <= $signed({1'b0, r_rng0}) * r_s;
            r_beam[1] <= r_beam[0];
        end
    end

    // Stage 2: round to Q4 millimetres
    logic signed [PW-1:0] w_pcr, w_psr;
    logic signed [PW-1:0] w_pcs, w_pss;
    logic signed [VW-1:0] r_vx, r_vy;
    localparam logic signed [PW-1:0] HALF26 = PW'(33'sd33554432);

    assign w_pcr = r_pc + HALF26;
    assign w_psr = r_ps + HALF26;
    assign w_pcs = w_pcr >>> 26;
    assign w_pss = w_psr >>> 26;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_vx      <= w_pcs[VW-1:0];
            r_vy      <= w_pss[VW-1:0];
            r_beam[2] <= r_beam[1];
        end
    end

    // Stage 3: matrix products
    logic signed [MW-1:0] r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_p00     <= r_m00 * r_vx;
            r_p01     <= r_m01 * r_vy;
            r_p10     <= r_m10 * r_vx;
            r_p11     <= r_m11 * r_vy;
            r_p20     <= r_m20 * r_vx;
            r_p21     <= r_m21 * r_vy;
            r_beam[3] <= r_beam[2];
        end
    end

    // Stage 4: row sums
    logic signed [AW-1:0] r_ax, r_ay, r_az;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_ax      <= AW'(r_p00) + AW'(r_p01);
            r_ay      <= AW'(r_p10) + AW'(r_p11);
            r_az      <= AW'(r_p20) + AW'(r_p21);
            r_beam[4] <= r_beam[3];
        end
    end

    // Stage 5: round, add offset and saturate
    function automatic logic signed [PT_W-1:0] finish(input logic signed [AW-1:0] acc,
                                                     input logic [23:0] off);
        logic signed [AW-1:0] rnd;
        logic signed [AW-1:0] shf;
        logic signed [FW-1:0] sum;
        logic signed [PT_W-1:0] res;
        rnd = acc + $signed({{(AW-32){1'b0}}, 1'b1, 31'd0});
        shf = rnd >>> 32;
        sum = FW'($signed(shf[TW-1:0])) + FW'($signed(off));
        if (sum > PT_MAX) begin
            res = PT_MAX[PT_W-1:0];
        end else if (sum < PT_MIN) begin
            res = PT_MIN[PT_W-1:0];
        end else begin
            res = sum[PT_W-1:0];
        end
        return res;
    endfunction

    logic signed [PT_W-1:0] r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_px      <= finish(r_ax, i_offset_x);
            r_py      <= finish(r_ay, i_offset_y);
            r_pz      <= finish(r_az, i_offset_z);
            r_beam[5] <= r_beam[4];
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_pz    = r_pz;
    assign o_beam  = r_beam[NST-1];

endmodule

// File: rtl/lidar_scan_to_world_points.sv
// Lidar range samples to world points: top level with configuration registers.
// Instantiates lsw_angle, lsw_cordic_stage and lsw_project; uses lsw_pkg.
//
// Usage:
//   Sample words enter on s_axis: tdata = {range_mm, beam_index}, tuser =
//   range_valid. A word with range_valid low is taken and dropped.
//   Each valid sample leaves as one point on m_axis: tdata = {pad, source_beam,
//   point_z, point_y, point_x}, coordinates in millimetres, saturated.
//   Registers (angle start/step, quaternion, offsets) are written on the
//   cfg channel, which is always ready; write them while the pipe is empty.
// Timing:
//   One sample per clock while no stage is held. The pipe has two angle
//   stages, one stage per CORDIC iteration (30) and six projection stages.
//   Every stage holds when its successor is full, so a stalled receiver
//   stops the pipe without loss; empty stages still fill, so input is taken
//   while a point waits on the output.
// Reset:
//   i_rst_n low clears all stage valid bits and returns the registers to
//   their defaults (quaternion word 0x40000000, everything else zero).
module lidar_scan_to_world_points #(
    parameter int RANGE_BITS = lsw_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_BITS = lsw_pkg::ANGLE_BITS_DEF,
    parameter int INDEX_BITS = lsw_pkg::INDEX_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // beam_index[15:0], range_mm[31:16]
    input  logic        s_axis_tuser,   // range_valid
    // point stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // point_x[24:0], point_y[49:25],
                                        // point_z[74:50], source_beam[90:75]
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import lsw_pkg::*;

    localparam int SIDE_W = BEAM_W + RANGE_BITS;

    // Configuration registers
    logic [15:0] r_angle_start, r_angle_step;
    logic [63:0] r_quat;
    logic [23:0] r_off_x, r_off_y, r_off_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start <= '0;
            r_angle_step  <= '0;
            r_quat        <= QUAT_RESET;
            r_off_x       <= '0;
            r_off_y       <= '0;
            r_off_z       <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ANGLE_START: r_angle_start <= i_cfg_data[15:0];
                CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[15:0];
                CFG_ROT_QUAT:    r_quat        <= i_cfg_data;
                CFG_OFFSET_X:    r_off_x       <= i_cfg_data[23:0];
                CFG_OFFSET_Y:    r_off_y       <= i_cfg_data[23:0];
                CFG_OFFSET_Z:    r_off_z       <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Drop invalid samples at the door
    logic                  w_in_valid;
    logic [INDEX_BITS-1:0] w_index;
    logic [SIDE_W-1:0]     w_side;

    assign w_in_valid = s_axis_tvalid && s_axis_tuser;
    assign w_index    = INDEX_BITS'(s_axis_tdata[15:0]);
    assign w_side     = {RANGE_BITS'(s_axis_tdata[31:16]), s_axis_tdata[15:0]};

    // Inter-stage links of the CORDIC chain
    logic                 w_v    [0:CORDIC_ITERS];
    logic                 w_rdy  [0:CORDIC_ITERS];
    logic signed [CW-1:0] w_x    [0:CORDIC_ITERS];
    logic signed [CW-1:0] w_y    [0:CORDIC_ITERS];
    logic signed [CW-1:0] w_z    [0:CORDIC_ITERS];
    logic                 w_flip [0:CORDIC_ITERS];
    logic [SIDE_W-1:0]    w_sd   [0:CORDIC_ITERS];

    lsw_angle #(
        .ANGLE_BITS (ANGLE_BITS),
        .INDEX_BITS (INDEX_BITS),
        .SIDE_W     (SIDE_W)
    ) u_angle (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_in_valid),
        .o_ready       (s_axis_tready),
        .i_index       (w_index),
        .i_side        (w_side),
        .i_angle_start (r_angle_start),
        .i_angle_step  (r_angle_step),
        .o_valid       (w_v[0]),
        .i_ready       (w_rdy[0]),
        .o_x           (w_x[0]),
        .o_y           (w_y[0]),
        .o_z           (w_z[0]),
        .o_flip        (w_flip[0]),
        .o_side        (w_sd[0])
    );

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cordic
        lsw_cordic_stage #(
            .ITER   (g),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_flip  (w_flip[g]),
            .i_side  (w_sd[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_flip  (w_flip[g+1]),
            .o_side  (w_sd[g+1])
        );
    end

    // Projection and pose transform
    logic signed [PT_W-1:0] w_px, w_py, w_pz;
    logic [BEAM_W-1:0]      w_beam;

    lsw_project #(
        .RANGE_BITS (RANGE_BITS)
    ) u_project (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_v[CORDIC_ITERS]),
        .o_ready    (w_rdy[CORDIC_ITERS]),
        .i_x        (w_x[CORDIC_ITERS]),
        .i_y        (w_y[CORDIC_ITERS]),
        .i_flip     (w_flip[CORDIC_ITERS]),
        .i_side     (w_sd[CORDIC_ITERS]),
        .i_quat     (r_quat),
        .i_offset_x (r_off_x),
        .i_offset_y (r_off_y),
        .i_offset_z (r_off_z),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_px       (w_px),
        .o_py       (w_py),
        .o_pz       (w_pz),
        .o_beam     (w_beam)
    );

    // Pack the output word, zero padded to whole bytes
    assign m_axis_tdata = {5'd0, w_beam, w_pz, w_py, w_px};

endmodule

// File: tb/sv/tb_lidar_scan_to_world_points.sv
// Self-checking testbench for lidar_scan_to_world_points: drives range samples,
// predicts each world point in fixed point and compares the point stream.
// Depends on rtl/lsw_pkg.sv and rtl/lidar_scan_to_world_points.sv.
module tb_lidar_scan_to_world_points;
    timeunit 1ns;
    timeprecision 1ps;
    import lsw_pkg::*;

    localparam int  IDLE_LIMIT  = 4000;
    localparam int  PIPE_DRAIN  = 45;
    localparam int  REPORT_MAX  = 10;
    localparam int  RAND_PHASES = 8;
    localparam int  PHASE_ITEMS = 200;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;
    localparam longint PT_HI = 16777215;
    localparam longint PT_LO = -16777216;
    localparam longint ATAN_TURN [30] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
        'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
        'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

    typedef struct {
        logic [15:0] beam;
        logic [15:0] range_mm;
        logic        range_ok;
    } t_sample;

    typedef struct {
        logic [24:0] px;
        logic [24:0] py;
        logic [24:0] pz;
        logic [15:0] beam;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // beam_index[15:0], range_mm[31:16]
    logic        s_axis_tuser = 1'b0; // range_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // point_x, point_y, point_z, source_beam
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // shadow of the block's registers
    logic [15:0] sh_start = '0;
    logic [15:0] sh_step = '0;
    logic [63:0] sh_quat = QUAT_RESET;
    logic [23:0] sh_off_x = '0;
    logic [23:0] sh_off_y = '0;
    logic [23:0] sh_off_z = '0;

    t_sample sample_queue[$];
    t_point  points_due[$];
    int      gap_left = 0;
    int      stall_left = 0;
    bit      send_steady = 0;
    bit      recv_steady = 0;
    int      mismatches = 0;
    int      samples_taken = 0;
    int      points_seen = 0;
    int      idle_cycles = 0;

    lidar_scan_to_world_points dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Round a Q32 sum to millimetres, add the offset and saturate
    function automatic logic [24:0] to_world_mm(longint acc, logic [23:0] off);
        longint v;
        v = ((acc + (64'sd1 <<< 31)) >>> 32) + longint'($signed(off));
        if (v > PT_HI) v = PT_HI;
        if (v < PT_LO) v = PT_LO;
        return v[24:0];
    endfunction

    // Beam angle, CORDIC sine and cosine, quaternion rotation, translation
    function automatic t_point project_sample(t_sample smp);
        logic [15:0] ang;
        logic [31:0] a32;
        logic        flip;
        longint x, y, z, nx, r, vx, vy, qw, qx, qy, qz;
        longint m00, m01, m10, m11, m20, m21;
        t_point p;
        ang = sh_start + smp.beam * sh_step;
        a32 = {ang, 16'h0000};
        flip = a32[31] ^ a32[30];
        if (flip) a32 = a32 - 32'h8000_0000;
        z = longint'($signed(a32));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_TURN[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_TURN[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        r = longint'(smp.range_mm);
        vx = (r * x + (64'sd1 <<< 25)) >>> 26;
        vy = (r * y + (64'sd1 <<< 25)) >>> 26;
        qw = longint'($signed(sh_quat[63:48]));
        qx = longint'($signed(sh_quat[47:32]));
        qy = longint'($signed(sh_quat[31:16]));
        qz = longint'($signed(sh_quat[15:0]));
        m00 = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        m01 = 2 * (qx * qy - qw * qz);
        m10 = 2 * (qx * qy + qw * qz);
        m11 = (64'sd1 <<< 28) - 2 * (qx * qx + qz * qz);
        m20 = 2 * (qx * qz - qw * qy);
        m21 = 2 * (qy * qz + qw * qx);
        p.px = to_world_mm(m00 * vx + m01 * vy, sh_off_x);
        p.py = to_world_mm(m10 * vx + m11 * vy, sh_off_y);
        p.pz = to_world_mm(m20 * vx + m21 * vy, sh_off_z);
        p.beam = smp.beam;
        return p;
    endfunction

    // Append one sample to the pending queue
    task automatic queue_sample(logic [15:0] beam, logic [15:0] rng, logic ok);
        t_sample smp;
        smp.beam     = beam;
        smp.range_mm = rng;
        smp.range_ok = ok;
        sample_queue.insert(sample_queue.size(), smp);
    endtask

    // Sample driver: predict on acceptance, then offer the next word after its gap
    always @(posedge i_clk) begin
        t_sample nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                samples_taken++;
                if (s_axis_tuser)
                    points_due.insert(points_due.size(),
                                      project_sample('{s_axis_tdata[15:0],
                                                       s_axis_tdata[31:16], 1'b1}));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    nxt = sample_queue.pop_front();
                    s_axis_tdata <= {nxt.range_mm, nxt.beam};
                    s_axis_tuser <= nxt.range_ok;
                    s_axis_tvalid <= 1'b1;
                    gap_left <= send_steady ? 0 : $urandom_range(0, 7);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Point monitor: stall at random, compare each word with the oldest prediction
    always @(posedge i_clk) begin
        t_point want;
        int     nstall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            nstall = stall_left;
            if (m_axis_tvalid && m_axis_tready) begin
                points_seen++;
                if (points_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected point word %h", m_axis_tdata);
                end else begin
                    want = points_due.pop_front();
                    if (m_axis_tdata[24:0] !== want.px || m_axis_tdata[49:25] !== want.py ||
                        m_axis_tdata[74:50] !== want.pz || m_axis_tdata[90:75] !== want.beam) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"point mismatch: exp x=%h y=%h z=%h beam=%h, ",
                                      "got x=%h y=%h z=%h beam=%h"},
                                     want.px, want.py, want.pz, want.beam,
                                     m_axis_tdata[24:0], m_axis_tdata[49:25],
                                     m_axis_tdata[74:50], m_axis_tdata[90:75]);
                    end
                end
                nstall = recv_steady ? 0 : $urandom_range(0, 7);
            end
            if (nstall > 0) begin
                stall_left <= nstall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left <= 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no word moved anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ANGLE_START: sh_start = val[15:0];
            CFG_ANGLE_STEP:  sh_step  = val[15:0];
            CFG_ROT_QUAT:    sh_quat  = val;
            CFG_OFFSET_X:    sh_off_x = val[23:0];
            CFG_OFFSET_Y:    sh_off_y = val[23:0];
            CFG_OFFSET_Z:    sh_off_z = val[23:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] st, logic [15:0] sp, logic [63:0] q,
                             logic [23:0] ox, logic [23:0] oy, logic [23:0] oz);
        write_reg(CFG_ANGLE_START, st);
        write_reg(CFG_ANGLE_STEP, sp);
        write_reg(CFG_ROT_QUAT, q);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
    endtask

    // Wait for every offered sample and predicted point, then let the pipe empty
    task automatic drain();
        do @(negedge i_clk);
        while (sample_queue.size() > 0 || s_axis_tvalid || points_due.size() > 0);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    function automatic logic [63:0] unit_quat();
        real a, b, c, d, n;
        a = real'($urandom_range(0, 65535)) - 32768.0;
        b = real'($urandom_range(0, 65535)) - 32768.0;
        c = real'($urandom_range(0, 65535)) - 32768.0;
        d = real'($urandom_range(0, 65535)) - 32768.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        return {16'(int'(16383.0 * a / n)), 16'(int'(16383.0 * b / n)),
                16'(int'(16383.0 * c / n)), 16'(int'(16383.0 * d / n))};
    endfunction

    function automatic logic [23:0] rand_offset();
        if ($urandom_range(0, 3) == 0)
            return 24'($urandom_range(0, 16777214) - 8388607);
        return 24'($urandom_range(0, 200000) - 100000);
    endfunction

    initial begin
        logic [15:0] scan_beam;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: rotation half a turn about y
        queue_sample(16'h0000, 16'h0000, 1'b1);
        queue_sample(16'h0000, 16'hFFFF, 1'b1);
        queue_sample(16'hFFFF, 16'hFFFF, 1'b1);
        queue_sample(16'hFFFF, 16'hFFFF, 1'b0);
        queue_sample(16'h1234, 16'h0400, 1'b1);
        drain();

        // wrap of the beam angle, identity rotation, largest positive offsets
        write_all(16'hFFFF, 16'h8000, 64'h4000_0000_0000_0000,
                  24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        for (int i = 0; i < 4; i++)
            queue_sample(16'(i), 16'hFFFF, 1'b1);
        queue_sample(16'hFFFF, 16'hFFFF, 1'b1);
        queue_sample(16'h0003, 16'h0000, 1'b0);
        drain();

        // octant boundaries, non-unit quaternion, offsets of -8388607; spare indexes
        write_all(16'h0000, 16'h2000, 64'h8000_7FFF_8000_7FFF,
                  24'h800001, 24'h800001, 24'h800001);
        write_reg(CFG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SPARE_7, 64'h0123_4567_89AB_CDEF);
        for (int i = 0; i < 9; i++)
            queue_sample(16'(i), 16'hFFFF, 1'b1);
        drain();

        // random scans, mostly consecutive beams with occasional jumps
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_all(16'($urandom), 16'($urandom),
                      (ph % 3 == 2) ? {$urandom, $urandom} : unit_quat(),
                      rand_offset(), rand_offset(), rand_offset());
            send_steady = (ph % 4 == 1);
            recv_steady = (ph % 4 == 2);
            scan_beam = 16'($urandom);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) == 0)
                    scan_beam = 16'($urandom);
                queue_sample(scan_beam,
                    ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom),
                    $urandom_range(0, 3) != 0);
                scan_beam++;
            end
            drain();
        end

        $display("Sent %0d samples over %0d register settings; %0d points checked.",
                 samples_taken, RAND_PHASES + 3, points_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
